/* src/btmx_pkg.sv */
package btmx_pkg;

	localparam int KEY_BITS_DEF       = 31;
	localparam int NODE_COUNT_MAX_DEF = 4096;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FRESH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic walk;
		logic fresh;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic go_walk;
		logic alloc;
		logic last_level;
		logic leaf;
		logic out_free;
	} ctl_sts_t;

endpackage

/* src/btmx_if.sv */
interface btmx_req_if #(parameter int KEY_BITS = btmx_pkg::KEY_BITS_DEF);
	logic                valid;
	logic                ready;
	logic [1:0]          command;
	logic [KEY_BITS-1:0] key;

	modport source (output valid, output command, output key, input ready);
	modport sink (input valid, input command, input key, output ready);
endinterface

interface btmx_rsp_if #(parameter int KEY_BITS = btmx_pkg::KEY_BITS_DEF);
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] max_xor;
	logic [1:0]          status;

	modport source (output valid, output max_xor, output status, input ready);
	modport sink (input valid, input max_xor, input status, output ready);
endinterface

/* src/btmx_ram.sv */
module btmx_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/btmx_ctrl.sv */
module btmx_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  btmx_pkg::ctl_sts_t  sts,
	output btmx_pkg::ctl_cmd_t  cmd
);

	import btmx_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = sts.go_walk ? ST_WALK : ST_FINISH;
				end
			end
			ST_WALK: begin
				if (sts.alloc) begin
					state_nxt = ST_FRESH;
				end else if (sts.last_level) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FRESH: begin
				if (sts.leaf) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_WALK: cmd.walk = 1'b1;
			ST_FRESH: cmd.fresh = 1'b1;
			ST_FINISH: cmd.finish = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

/* src/btmx_dp.sv */
module btmx_dp #(
	parameter int KEY_BITS       = btmx_pkg::KEY_BITS_DEF,
	parameter int NODE_COUNT_MAX = btmx_pkg::NODE_COUNT_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          command,
	input  logic [KEY_BITS-1:0] key,
	input  btmx_pkg::ctl_cmd_t  cmd,
	output btmx_pkg::ctl_sts_t  sts,
	btmx_rsp_if.source          rsp
);

	import btmx_pkg::*;

	localparam int IDX_W = $clog2(NODE_COUNT_MAX);
	localparam int CNT_W = $clog2(NODE_COUNT_MAX + 1);
	localparam int LVL_W = $clog2(KEY_BITS);
	localparam int ENT_W = 2 * IDX_W;

	// node state
	logic [1:0][IDX_W-1:0] root_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  nonempty_q;

	// per-request state
	cmd_t                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [LVL_W-1:0]      lvl_q;
	logic [IDX_W-1:0]      cur_q;
	logic [KEY_BITS-1:0]   best_q;
	logic                  leaf_q;
	status_t               sts_q;

	// result register
	logic                  valid_q;
	logic [KEY_BITS-1:0]   max_xor_q;
	status_t               status_q;

	logic [ENT_W-1:0]      ram_rdata;
	logic [1:0][IDX_W-1:0] node_dat;
	logic [1:0][IDX_W-1:0] wr_ent;
	logic                  ram_we;
	logic                  kbit;
	logic                  sel;
	logic                  is_query;
	logic [IDX_W-1:0]      c_sel;
	logic [IDX_W-1:0]      c_oth;
	logic [IDX_W-1:0]      nxt;
	logic [IDX_W-1:0]      cnt_idx;
	logic                  alloc;
	logic [CNT_W-1:0]      free_cnt;
	logic                  full;
	logic                  go_walk;

	assign node_dat = (cur_q == '0) ? root_q : ram_rdata;
	assign kbit     = key_q[lvl_q];
	assign is_query = (cmd_q == CMD_QUERY);
	assign sel      = is_query ? ~kbit : kbit;
	assign c_sel    = node_dat[sel];
	assign c_oth    = node_dat[~sel];
	assign nxt      = (is_query && c_sel == '0) ? c_oth : c_sel;
	assign alloc    = !is_query && (c_sel == '0);
	assign cnt_idx  = cnt_q[IDX_W-1:0];

	assign free_cnt = CNT_W'(NODE_COUNT_MAX) - cnt_q;
	assign full     = free_cnt < CNT_W'(KEY_BITS);
	assign go_walk  = (command == CMD_INSERT && !full) ||
		(command == CMD_QUERY && nonempty_q);

	assign sts.go_walk    = go_walk;
	assign sts.alloc      = alloc;
	assign sts.last_level = (lvl_q == '0);
	assign sts.leaf       = leaf_q;
	assign sts.out_free   = !valid_q || rsp.ready;

	// parent update while walking, fresh path nodes afterwards
	always_comb begin
		wr_ent = cmd.fresh ? '0 : node_dat;
		if (!(cmd.fresh && leaf_q)) begin
			wr_ent[kbit] = cnt_idx;
		end
	end

	assign ram_we = (cmd.walk && alloc && cur_q != '0) || cmd.fresh;

	btmx_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NODE_COUNT_MAX)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cur_q),
		.wdata (wr_ent),
		.raddr (nxt),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q     <= '0;
			cnt_q      <= CNT_W'(1);
			nonempty_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (command == CMD_CLEAR) begin
					root_q     <= '0;
					cnt_q      <= CNT_W'(1);
					nonempty_q <= 1'b0;
				end else if (command == CMD_INSERT && !full) begin
					nonempty_q <= 1'b1;
				end
			end
			if (cmd.walk && alloc) begin
				if (cur_q == '0) begin
					root_q[kbit] <= cnt_idx;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.fresh && !leaf_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= cmd_t'(command);
			key_q  <= key;
			lvl_q  <= LVL_W'(KEY_BITS - 1);
			cur_q  <= '0;
			best_q <= '0;
			leaf_q <= 1'b0;
			if (command == CMD_INSERT && full) begin
				sts_q <= STS_FULL;
			end else if (command == CMD_QUERY && !nonempty_q) begin
				sts_q <= STS_EMPTY;
			end else begin
				sts_q <= STS_OK;
			end
		end
		if (cmd.walk) begin
			if (alloc) begin
				cur_q  <= cnt_idx;
				leaf_q <= (lvl_q == '0);
			end else begin
				cur_q <= nxt;
				if (is_query && c_sel != '0) begin
					best_q[lvl_q] <= 1'b1;
				end
			end
			if (lvl_q != '0) begin
				lvl_q <= lvl_q - LVL_W'(1);
			end
		end
		if (cmd.fresh && !leaf_q) begin
			cur_q <= cnt_idx;
			if (lvl_q == '0) begin
				leaf_q <= 1'b1;
			end else begin
				lvl_q <= lvl_q - LVL_W'(1);
			end
		end
		if (cmd.finish) begin
			max_xor_q <= best_q;
			status_q  <= sts_q;
		end
	end

	assign rsp.valid   = valid_q;
	assign rsp.max_xor = max_xor_q;
	assign rsp.status  = status_q;

endmodule

/* src/binary_trie_max_xor_top.sv */
// channel | dir | payload           | handshake
// req     | in  | command, key      | valid / ready
// rsp     | out | max_xor, status   | valid / ready
//
// one request at a time; insert and query walk one trie level per cycle
// through the node memory read port; an insert that allocates goes on to write
// fresh path nodes; clear, rejected insert or empty query skip the walk
// reset leaves an empty trie at once, no clearing pass
// a waiting response holds only the finish state of the next request
module binary_trie_max_xor_top #(
	parameter int KEY_BITS       = btmx_pkg::KEY_BITS_DEF,
	parameter int NODE_COUNT_MAX = btmx_pkg::NODE_COUNT_MAX_DEF
) (
	input logic        clk,
	input logic        arst_n,
	btmx_req_if.sink   req,
	btmx_rsp_if.source rsp
);

	import btmx_pkg::*;

	ctl_cmd_t ctl_cmd;
	ctl_sts_t ctl_sts;
	logic     req_ready;

	assign req.ready = req_ready;

	btmx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (ctl_sts),
		.cmd       (ctl_cmd)
	);

	btmx_dp #(
		.KEY_BITS       (KEY_BITS),
		.NODE_COUNT_MAX (NODE_COUNT_MAX)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.command (req.command),
		.key     (req.key),
		.cmd     (ctl_cmd),
		.sts     (ctl_sts),
		.rsp     (rsp)
	);

endmodule

/* test/btmx_checker.sv */
`timescale 1ns / 100ps

module btmx_checker #(
	parameter int KEY_BITS       = btmx_pkg::KEY_BITS_DEF,
	parameter int NODE_COUNT_MAX = btmx_pkg::NODE_COUNT_MAX_DEF
) (
	input  logic clk,
	input  logic arst_n,
	btmx_req_if  req,
	btmx_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);
	import btmx_pkg::*;

	localparam int IDX_W = $clog2(NODE_COUNT_MAX);

	typedef logic [IDX_W-1:0] node_idx_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] max_xor;
		status_t             status;
	} trie_rsp_t;

	node_idx_t   kids [NODE_COUNT_MAX][2];
	logic [IDX_W:0] node_total;
	logic        has_keys;
	trie_rsp_t   predicted_rsp[$];
	trie_rsp_t   head_rsp;

	function automatic trie_rsp_t trie_apply(logic [1:0] cmd, logic [KEY_BITS-1:0] k);
		trie_rsp_t res;
		node_idx_t node;
		node_idx_t nxt;
		logic      b;
		res.max_xor = '0;
		res.status  = STS_OK;
		node        = '0;
		case (cmd)
			CMD_INSERT: begin
				if (NODE_COUNT_MAX - int'(node_total) < KEY_BITS) begin
					res.status = STS_FULL;
				end else begin
					for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
						b   = k[lvl];
						nxt = kids[node][b];
						if (nxt == '0) begin
							nxt           = node_total[IDX_W-1:0];
							node_total    = node_total + 1'b1;
							kids[nxt][0]  = '0;
							kids[nxt][1]  = '0;
							kids[node][b] = nxt;
						end
						node = nxt;
					end
					has_keys = 1'b1;
				end
			end
			CMD_QUERY: begin
				if (!has_keys) begin
					res.status = STS_EMPTY;
				end else begin
					for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
						b   = ~k[lvl];
						nxt = kids[node][b];
						if (nxt != '0) begin
							res.max_xor[lvl] = 1'b1;
							node             = nxt;
						end else begin
							node = kids[node][~b];
						end
					end
				end
			end
			CMD_CLEAR: begin
				kids[0][0] = '0;
				kids[0][1] = '0;
				node_total = (IDX_W+1)'(1);
				has_keys   = 1'b0;
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kids[0][0] = '0;
			kids[0][1] = '0;
			node_total = (IDX_W+1)'(1);
			has_keys   = 1'b0;
			predicted_rsp.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (predicted_rsp.size() == 0) begin
					$error("response with no request pending: max_xor %0h status %0d",
						rsp.max_xor, rsp.status);
					fail_count++;
				end else begin
					head_rsp = predicted_rsp.pop_front();
					if (rsp.max_xor !== head_rsp.max_xor) begin
						$error("max_xor: expected %0h, got %0h", head_rsp.max_xor, rsp.max_xor);
						fail_count++;
					end
					if (rsp.status !== head_rsp.status) begin
						$error("status: expected %0d, got %0d", head_rsp.status, rsp.status);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				predicted_rsp.insert(predicted_rsp.size(), trie_apply(req.command, req.key));
		end
		pending = predicted_rsp.size();
	end

endmodule

/* test/tb_binary_trie_max_xor_top.sv */
`timescale 1ns / 100ps

module tb_binary_trie_max_xor_top;
	import btmx_pkg::*;

	localparam int KEY_BITS       = 31;
	localparam int NODE_COUNT_MAX = 4096;
	localparam int ITEM_TARGET    = 1450;
	localparam int CALM_FROM      = 1300;
	localparam int FILL_SPAN      = 250;
	localparam int DRAIN_CYCLES   = 2 * (KEY_BITS + 3) + 10;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int POOL_MAX       = 64;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	btmx_req_if #(.KEY_BITS(KEY_BITS)) req ();
	btmx_rsp_if #(.KEY_BITS(KEY_BITS)) rsp ();

	int   fail_count;
	int   pending;
	int   cycles;
	int   stall_left;
	int   sent;
	logic gaps_on = 1'b0;

	logic [KEY_BITS-1:0] key_pool[$];

	binary_trie_max_xor_top #(
		.KEY_BITS(KEY_BITS),
		.NODE_COUNT_MAX(NODE_COUNT_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	btmx_checker #(
		.KEY_BITS(KEY_BITS),
		.NODE_COUNT_MAX(NODE_COUNT_MAX)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// response back-pressure in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			rsp.ready  <= 1'b0;
			stall_left = $urandom_range(0, 6);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	function automatic logic [KEY_BITS-1:0] pick_key();
		logic [KEY_BITS-1:0] k;
		k = KEY_BITS'($urandom);
		case ($urandom_range(0, 7))
			0: k = '0;
			1: k = '1;
			2, 3: begin
				if (key_pool.size() != 0)
					k = key_pool[$urandom_range(0, key_pool.size() - 1)]
						^ (KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1));
			end
			4: begin
				if (key_pool.size() != 0)
					k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			end
			5: begin
				if (key_pool.size() != 0)
					k = ~key_pool[$urandom_range(0, key_pool.size() - 1)];
			end
			default: ;
		endcase
		return k;
	endfunction

	task automatic send_request(input logic [1:0] cmd, input logic [KEY_BITS-1:0] k);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req.valid   <= 1'b1;
		req.command <= cmd;
		req.key     <= k;
		do @(posedge clk); while (!req.ready);
		sent++;
		if (cmd == CMD_INSERT) begin
			key_pool.insert(key_pool.size(), k);
			if (key_pool.size() > POOL_MAX)
				void'(key_pool.pop_front());
		end else if (cmd == CMD_CLEAR) begin
			key_pool.delete();
		end
	endtask

	initial begin
		logic [KEY_BITS-1:0] base;
		int                  r;
		req.valid   = 1'b0;
		req.command = CMD_INSERT;
		req.key     = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_request(CMD_QUERY, '0);
		send_request(CMD_QUERY, '1);
		send_request(CMD_INSERT, '0);
		send_request(CMD_QUERY, '0);
		send_request(CMD_QUERY, '1);
		send_request(CMD_INSERT, '1);
		send_request(CMD_QUERY, '0);
		send_request(CMD_QUERY, 31'h2AAA_AAAA);
		send_request(CMD_INSERT, '0);
		send_request(CMD_UNUSED, '1);
		send_request(CMD_CLEAR, '1);
		send_request(CMD_QUERY, '0);
		send_request(CMD_UNUSED, '0);
		send_request(CMD_INSERT, 31'h5555_5555);
		send_request(CMD_INSERT, 31'h2AAA_AAAA);
		send_request(CMD_QUERY, 31'h5555_5555);
		send_request(CMD_INSERT, 31'h0000_0001);
		send_request(CMD_INSERT, 31'h4000_0000);
		send_request(CMD_QUERY, 31'h0000_0001);
		send_request(CMD_QUERY, 31'h4000_0000);
		send_request(CMD_CLEAR, '0);
		send_request(CMD_INSERT, 31'h4000_0000);
		send_request(CMD_QUERY, 31'h3FFF_FFFF);

		while (sent < ITEM_TARGET) begin
			gaps_on = (sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
			case ((sent + FILL_SPAN > ITEM_TARGET) ? 2 : $urandom_range(0, 3))
				0: begin
					// fill the node memory past the full threshold
					send_request(CMD_CLEAR, KEY_BITS'($urandom));
					repeat (200 + $urandom_range(0, 20))
						send_request(CMD_INSERT, KEY_BITS'($urandom));
					send_request(CMD_INSERT, key_pool[$urandom_range(0, key_pool.size() - 1)]);
					repeat ($urandom_range(5, 15))
						send_request(CMD_QUERY, pick_key());
				end
				1: begin
					// keys sharing a long prefix
					base = KEY_BITS'($urandom);
					repeat ($urandom_range(15, 40)) begin
						r = $urandom_range(0, 1);
						send_request(r == 0 ? CMD_INSERT : CMD_QUERY,
							base ^ KEY_BITS'($urandom_range(0, 255)));
					end
				end
				default: begin
					repeat ($urandom_range(10, 40)) begin
						r = $urandom_range(0, 19);
						if (r < 8)
							send_request(CMD_INSERT, pick_key());
						else if (r < 17)
							send_request(CMD_QUERY, pick_key());
						else if (r == 17)
							send_request(CMD_CLEAR, pick_key());
						else if (r == 18)
							send_request(CMD_UNUSED, KEY_BITS'($urandom));
						else
							send_request(CMD_QUERY, KEY_BITS'($urandom));
					end
				end
			endcase
		end

		req.valid <= 1'b0;
		gaps_on = 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
